// File: src/pdm_pkg.sv
// Package for the PWM input period and duty meter: word types, codes and constants.
package pdm_pkg;

  // Field widths
  localparam int unsigned TsBits     = 32;
  localparam int unsigned DutyBits   = 10;
  localparam int unsigned CfgIdxBits = 8;

  // Narrow capture default width
  localparam int unsigned NarrowTsBitsDefault = 16;

  // Duty dividend: high_len * 1000 + period / 2 fits in 42 bits
  localparam int unsigned DvdBits  = 42;
  localparam int unsigned StepBits = 6;

  // Reset values of the configuration registers
  localparam logic [31:0] ClockHzReset  = 32'd120000000;
  localparam logic [31:0] MinHzReset    = 32'd24800;
  localparam logic [31:0] MaxHzReset    = 32'd25200;

  // Duty limits in tenths of a percent
  localparam logic [DutyBits-1:0] DutyFull = 10'd1000;
  localparam logic [DutyBits-1:0] DutySat  = 10'd1023;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgClockHz     = 8'd0;
  localparam logic [CfgIdxBits-1:0] CfgValidMinHz  = 8'd1;
  localparam logic [CfgIdxBits-1:0] CfgValidMaxHz  = 8'd2;
  localparam logic [CfgIdxBits-1:0] CfgCaptureMode = 8'd3;

  // Input opcodes
  localparam logic OpEdge = 1'b0;
  localparam logic OpTick = 1'b1;

  // Input word
  typedef struct packed {
    logic              op;
    logic [TsBits-1:0] timestamp;
    logic              level;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic                sample_present;
    logic                sample_valid;
    logic [31:0]         freq_hz;
    logic [DutyBits-1:0] duty_tenths;
    logic [31:0]         edges_counted;
    logic [31:0]         suppressed_total;
    logic [31:0]         held_freq_hz;
    logic [DutyBits-1:0] held_duty_tenths;
    logic                held_present;
  } out_word_t;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL_A = 6'b000010,
    ST_MUL_B = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

// File: src/pwm_input_period_duty_meter_core.sv
// PWM input period and duty meter: edge capture, bit-serial dividers and result register.
// Edge word: accepted while idle, updates rise time, period and high time, gives no result.
// Tick word: with a sample present, two setup steps (ST_MUL_A, ST_MUL_B), 42 bit-serial division
//   steps, one check step (ST_FIN) and a load that waits on out_ready; without one, check and load.
// The divider retires one quotient bit per cycle; no new word is taken until a tick is done.
// Reset (rst, synchronous, active high) clears all capture state and loads register defaults.
module pwm_input_period_duty_meter_core
  import pdm_pkg::*;
#(
  parameter int unsigned NARROW_TIMESTAMP_BITS = NarrowTsBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam logic [63:0] MaskWide   = (64'd1 << NARROW_TIMESTAMP_BITS) - 64'd1;
  localparam logic [31:0] NarrowMask = MaskWide[31:0];
  localparam logic [StepBits-1:0] LastStep = StepBits'(DvdBits - 1);

  // Configuration registers
  logic [31:0] clock_hz, valid_min_hz, valid_max_hz;
  logic        capture_mode;

  // Capture state
  logic [31:0] rise_time, period_len, high_len;
  logic        rise_seen, period_seen, high_set, expect_rise;
  logic [31:0] edge_tally, suppress_tally, valid_freq;
  logic [DutyBits-1:0] valid_duty;
  logic        valid_seen;

  // Sequencer and datapath
  state_t               state;
  logic [StepBits-1:0]  step_cnt;
  logic [DvdBits-1:0]   dvd_d, dvd_f;
  logic [36:0]          sub24;
  logic [31:0]          rem_d, rem_f, q_f;
  logic [DutyBits-1:0]  q_d;
  logic                 q_ovf, present_r, hi_le, valid_r;
  logic [DutyBits-1:0]  duty_r;

  logic in_acc;
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  // Edge classification and delta
  logic        rising;
  logic [31:0] now_ts, mask, delta;
  always_comb begin
    if (capture_mode) begin
      rising = in_data.level;
      mask   = '1;
    end else begin
      rising = expect_rise;
      mask   = NarrowMask;
    end
    now_ts = in_data.timestamp & mask;
    delta  = (now_ts - rise_time) & mask;
  end

  logic present_now;
  assign present_now = period_seen && high_set && (period_len != '0);

  // One restoring division step for each quotient
  logic [32:0] cand_d, cand_f;
  logic [33:0] diff_d, diff_f;
  logic        ge_d, ge_f;
  always_comb begin
    cand_d = {rem_d, dvd_d[DvdBits-1]};
    cand_f = {rem_f, dvd_f[DvdBits-1]};
    diff_d = {1'b0, cand_d} - {2'b00, period_len};
    diff_f = {1'b0, cand_f} - {2'b00, period_len};
    ge_d   = !diff_d[33];
    ge_f   = !diff_f[33];
  end

  // Tick completion values
  logic        fire, do_suppress, do_hold;
  logic [31:0] suppress_next, valid_freq_next;
  logic [DutyBits-1:0] valid_duty_next;
  logic        valid_seen_next;
  always_comb begin
    fire            = (state == ST_DONE) && (!out_valid || out_ready);
    do_hold         = fire && valid_r;
    do_suppress     = fire && present_r && !valid_r;
    suppress_next   = do_suppress ? suppress_tally + 32'd1 : suppress_tally;
    valid_freq_next = do_hold ? q_f : valid_freq;
    valid_duty_next = do_hold ? duty_r : valid_duty;
    valid_seen_next = valid_seen || do_hold;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz     <= ClockHzReset;
      valid_min_hz <= MinHzReset;
      valid_max_hz <= MaxHzReset;
      capture_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgClockHz:     clock_hz     <= cfg_data;
        CfgValidMinHz:  valid_min_hz <= cfg_data;
        CfgValidMaxHz:  valid_max_hz <= cfg_data;
        CfgCaptureMode: capture_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture state and held snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_time      <= '0;
      rise_seen      <= 1'b0;
      period_len     <= '0;
      period_seen    <= 1'b0;
      high_len       <= '0;
      high_set       <= 1'b0;
      expect_rise    <= 1'b1;
      edge_tally     <= '0;
      suppress_tally <= '0;
      valid_freq     <= '0;
      valid_duty     <= '0;
      valid_seen     <= 1'b0;
    end else begin
      if (in_acc && in_data.op == OpEdge) begin
        edge_tally <= edge_tally + 32'd1;
        if (!capture_mode) begin
          expect_rise <= !expect_rise;
        end
        if (rising) begin
          if (rise_seen) begin
            period_len  <= delta;
            period_seen <= (delta != '0);
          end
          rise_time <= now_ts;
          rise_seen <= 1'b1;
        end else if (rise_seen) begin
          high_len <= delta;
          high_set <= 1'b1;
        end
      end
      if (fire) begin
        edge_tally <= '0;
      end
      suppress_tally <= suppress_next;
      valid_freq     <= valid_freq_next;
      valid_duty     <= valid_duty_next;
      valid_seen     <= valid_seen_next;
    end
  end

  // Tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && in_data.op == OpTick) begin
            state <= present_now ? ST_MUL_A : ST_FIN;
          end
        end
        ST_MUL_A: state <= ST_MUL_B;
        ST_MUL_B: state <= ST_DIV;
        ST_DIV:   if (step_cnt == LastStep) state <= ST_FIN;
        ST_FIN:   state <= ST_DONE;
        ST_DONE:  if (fire) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        present_r <= present_now;
        q_f       <= '0;
        q_d       <= '0;
        q_ovf     <= 1'b0;
        hi_le     <= 1'b0;
        step_cnt  <= '0;
        rem_d     <= '0;
        rem_f     <= '0;
      end
      ST_MUL_A: begin
        // high * 1024 + period / 2, and high * 24 on the side
        dvd_d <= {high_len, 10'b0} + {11'b0, period_len[31:1]};
        sub24 <= {1'b0, high_len, 4'b0} + {2'b00, high_len, 3'b0};
        dvd_f <= {10'b0, clock_hz};
      end
      ST_MUL_B: begin
        dvd_d <= dvd_d - {5'b0, sub24};
        hi_le <= (high_len <= period_len);
      end
      ST_DIV: begin
        dvd_d    <= {dvd_d[DvdBits-2:0], 1'b0};
        dvd_f    <= {dvd_f[DvdBits-2:0], 1'b0};
        rem_d    <= ge_d ? diff_d[31:0] : cand_d[31:0];
        rem_f    <= ge_f ? diff_f[31:0] : cand_f[31:0];
        q_f      <= {q_f[30:0], ge_f};
        q_d      <= {q_d[DutyBits-2:0], ge_d};
        q_ovf    <= q_ovf || q_d[DutyBits-1];
        step_cnt <= step_cnt + 1'b1;
      end
      ST_FIN: begin
        // plausibility checks on the finished quotients
        duty_r  <= q_ovf ? DutySat : q_d;
        valid_r <= present_r && (q_f >= valid_min_hz) && (q_f <= valid_max_hz) &&
                   !q_ovf && (q_d <= DutyFull) && hi_le;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.sample_present   <= present_r;
      out_data.sample_valid     <= valid_r;
      out_data.freq_hz          <= q_f;
      out_data.duty_tenths      <= duty_r;
      out_data.edges_counted    <= edge_tally;
      out_data.suppressed_total <= suppress_next;
      out_data.held_freq_hz     <= valid_freq_next;
      out_data.held_duty_tenths <= valid_duty_next;
      out_data.held_present     <= valid_seen_next;
    end
  end

endmodule

// File: src/pdm_chk.sv
// Port-level checker for the PWM input period and duty meter, bound to the top level.
module pdm_chk
  import pdm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A valid sample must also be a present sample
  a_valid_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sample_valid |-> out_data.sample_present)
    else $error("valid sample without a present sample");

  // A valid sample is copied into the held snapshot of the same word
  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sample_valid |->
      out_data.held_present && (out_data.held_freq_hz == out_data.freq_hz) &&
      (out_data.held_duty_tenths == out_data.duty_tenths))
    else $error("held snapshot does not follow a valid sample");

  // Held duty never exceeds full scale
  a_held_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.held_duty_tenths <= DutyFull)
    else $error("held duty above full scale");

  // No result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind pwm_input_period_duty_meter_core pdm_chk u_pdm_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
